FILE: sv/kfpu_pkg.sv
// Kalman predict/update unit: shared codes, item types and state encodings.
// No dependencies; imported by the top level.
`default_nettype none

package kfpu_pkg;

	// operation codes
	localparam logic [1:0] OP_WRITE   = 2'd0;
	localparam logic [1:0] OP_READ    = 2'd1;
	localparam logic [1:0] OP_PREDICT = 2'd2;
	localparam logic [1:0] OP_UPDATE  = 2'd3;

	// matrix select codes
	localparam logic [2:0] SEL_F = 3'd0;
	localparam logic [2:0] SEL_B = 3'd1;
	localparam logic [2:0] SEL_Q = 3'd2;
	localparam logic [2:0] SEL_H = 3'd3;
	localparam logic [2:0] SEL_R = 3'd4;
	localparam logic [2:0] SEL_X = 3'd5;
	localparam logic [2:0] SEL_P = 3'd6;

	// status codes
	localparam logic [1:0] STS_OK       = 2'd0;
	localparam logic [1:0] STS_SINGULAR = 2'd1;
	localparam logic [1:0] STS_RANGE    = 2'd2;
	localparam logic [1:0] STS_SAT      = 2'd3;

	// configuration registers
	localparam int         CFG_IDX_W      = 2;
	localparam int         CFG_DATA_W     = 3;
	localparam logic [1:0] CFG_STATE_SIZE = 2'd0;
	localparam logic [1:0] CFG_MEAS_SIZE  = 2'd1;
	localparam logic [1:0] CFG_CTRL_SIZE  = 2'd2;

	typedef struct packed {
		logic [1:0]         operation;
		logic [2:0]         matrix_sel;
		logic [1:0]         row_index;
		logic [1:0]         col_index;
		logic signed [31:0] elem_value;
		logic signed [31:0] vector_first;
		logic signed [31:0] vector_second;
	} cmd_item_t;

	typedef struct packed {
		logic signed [31:0] read_value;
		logic [1:0]         status;
	} rsp_item_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RD,
		ST_ELEM,
		ST_INIT,
		ST_RA,
		ST_RB,
		ST_MUL,
		ST_ACC,
		ST_DIV,
		ST_DIVF,
		ST_WB,
		ST_DONE
	} state_t;

	// one phase per matrix expression of predict and update
	typedef enum logic [3:0] {
		PH_PX,    // xn = F x + B u
		PH_PT,    // t = P F'
		PH_PP,    // pn = F t + Q
		PH_UY,    // y = z - H x
		PH_UPHT,  // pht = P H'
		PH_US,    // s = H pht + R
		PH_UDET,  // det of s (or s00 alone)
		PH_UINV,  // inv(s), 2x2 only
		PH_UK,    // gain
		PH_UX,    // xn = x + K y
		PH_UM,    // m = I - K H
		PH_UPN,   // pn = m P
		PH_CX,    // copy xn to x
		PH_CP     // copy pn to P
	} phase_t;

	typedef enum logic [1:0] {
		INIT_ZERO,
		INIT_ONE_DIAG,
		INIT_MEM,
		INIT_ZIN
	} init_kind_t;

endpackage

`default_nettype wire

FILE: sv/kfpu_stream_if.sv
// Valid/ready stream channel carrying one item of type T.
// No dependencies.
`default_nettype none

interface kfpu_stream_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: sv/kalman_filter_predict_update_unit.sv
// Kalman filter predict/update engine over a stored matrix bank in one RAM.
// Depends on kfpu_pkg, kfpu_stream_if and kfpu_ram.
`default_nettype none

// One command item in, one response item out. Element writes and reads end with
// the hand-off to the response register. Predict and update run as a
// microsequence over a single RAM that holds both the matrix bank and all
// intermediate matrices (P F', y, P H', S, inv(S), K, I - K H, new x and P).
// Every multiply-accumulate term runs through two RAM reads through the one
// read port, the 32x32 product, and round and accumulate; every division runs
// on a radix-2 divider. Update takes longer than predict. The bank reads as
// zero after reset: each bank word has a valid bit cleared by reset, so no
// clearing pass is needed. Status is 2 for an element outside the active shape,
// 1 when S is singular (state untouched), 3 when any result saturated.

module kalman_filter_predict_update_unit
	import kfpu_pkg::*;
#(
	parameter int MAX_STATE = 4,
	parameter int MAX_MEAS  = 2,
	parameter int MAX_CTRL  = 2,
	parameter int FRAC_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	kfpu_stream_if.sink           cmd,
	kfpu_stream_if.source         rsp
);

	localparam int MS = MAX_STATE;
	localparam int MM = MAX_MEAS;
	localparam int MC = MAX_CTRL;

	// bank layout, row-major at maximum sizes
	localparam int OFF_F      = 0;
	localparam int OFF_B      = OFF_F + MS * MS;
	localparam int OFF_Q      = OFF_B + MS * MC;
	localparam int OFF_H      = OFF_Q + MS * MS;
	localparam int OFF_R      = OFF_H + MM * MS;
	localparam int OFF_X      = OFF_R + MM * MM;
	localparam int OFF_P      = OFF_X + MS;
	localparam int BANK_DEPTH = OFF_P + MS * MS;
	// scratch above the bank
	localparam int OFF_T      = BANK_DEPTH;
	localparam int OFF_PN     = OFF_T + MS * MS;
	localparam int OFF_XN     = OFF_PN + MS * MS;
	localparam int OFF_Y      = OFF_XN + MS;
	localparam int OFF_PHT    = OFF_Y + MM;
	localparam int OFF_S      = OFF_PHT + MS * MM;
	localparam int OFF_SI     = OFF_S + MM * MM;
	localparam int OFF_KG     = OFF_SI + MM * MM;
	localparam int MEM_DEPTH  = OFF_KG + MS * MM;

	localparam int AW = $clog2(MEM_DEPTH);
	localparam int BW = $clog2(BANK_DEPTH);
	localparam int CW = $clog2(MS + MC + 1);

	localparam int NS_RST = (MS < 4) ? MS : 4;

	localparam logic signed [63:0] HALF = 64'sd1 <<< (FRAC_BITS - 1);
	localparam logic signed [63:0] ONE  = 64'sd1 <<< FRAC_BITS;
	localparam logic signed [63:0] SMAX = 64'sd2147483647;
	localparam logic signed [63:0] SMIN = -64'sd2147483648;

	typedef struct packed {
		logic [CW-1:0] nterms;
		logic [CW-1:0] ni;
		logic [CW-1:0] nj;
		init_kind_t    init;
		logic [AW-1:0] init_addr;
		logic [AW-1:0] a_addr;
		logic [AW-1:0] b_addr;
		logic [AW-1:0] dest_addr;
		logic          b_in;
		logic [CW-1:0] u_idx;
		logic          tneg;
		logic          is_div;
		logic          num_neg;
		logic          dest_det;
	} desc_t;

	function automatic logic [CW-1:0] clamp_f(input logic [CFG_DATA_W-1:0] v, input int hi);
		int t;
		t = int'(v);
		if (t < 1) t = 1;
		if (t > hi) t = hi;
		return CW'(t);
	endfunction

	// element addressing and loop bounds of one multiply-accumulate term
	function automatic desc_t desc_f(input phase_t ph, input logic [CW-1:0] i,
			input logic [CW-1:0] j, input logic [CW-1:0] k, input logic [CW-1:0] ns,
			input logic [CW-1:0] nm, input logic [CW-1:0] nc);
		desc_t r;
		int    ii;
		int    jj;
		int    kk;
		int    nsi;
		r   = '0;
		ii  = int'(i);
		jj  = int'(j);
		kk  = int'(k);
		nsi = int'(ns);
		r.init = INIT_ZERO;
		case (ph)
			PH_PX: begin
				r.ni = ns; r.nj = CW'(1); r.nterms = ns + nc;
				if (kk < nsi) begin
					r.a_addr = AW'(OFF_F + ii * MS + kk);
					r.b_addr = AW'(OFF_X + kk);
				end else begin
					r.a_addr = AW'(OFF_B + ii * MC + kk - nsi);
					r.b_in   = 1'b1;
					r.u_idx  = CW'(kk - nsi);
				end
				r.dest_addr = AW'(OFF_XN + ii);
			end
			PH_PT: begin
				r.ni = ns; r.nj = ns; r.nterms = ns;
				r.a_addr    = AW'(OFF_P + ii * MS + kk);
				r.b_addr    = AW'(OFF_F + jj * MS + kk);
				r.dest_addr = AW'(OFF_T + ii * MS + jj);
			end
			PH_PP: begin
				r.ni = ns; r.nj = ns; r.nterms = ns;
				r.init      = INIT_MEM;
				r.init_addr = AW'(OFF_Q + ii * MS + jj);
				r.a_addr    = AW'(OFF_F + ii * MS + kk);
				r.b_addr    = AW'(OFF_T + kk * MS + jj);
				r.dest_addr = AW'(OFF_PN + ii * MS + jj);
			end
			PH_UY: begin
				r.ni = nm; r.nj = CW'(1); r.nterms = ns;
				r.init      = INIT_ZIN;
				r.tneg      = 1'b1;
				r.a_addr    = AW'(OFF_H + ii * MS + kk);
				r.b_addr    = AW'(OFF_X + kk);
				r.dest_addr = AW'(OFF_Y + ii);
			end
			PH_UPHT: begin
				r.ni = ns; r.nj = nm; r.nterms = ns;
				r.a_addr    = AW'(OFF_P + ii * MS + kk);
				r.b_addr    = AW'(OFF_H + jj * MS + kk);
				r.dest_addr = AW'(OFF_PHT + ii * MM + jj);
			end
			PH_US: begin
				r.ni = nm; r.nj = nm; r.nterms = ns;
				r.init      = INIT_MEM;
				r.init_addr = AW'(OFF_R + ii * MM + jj);
				r.a_addr    = AW'(OFF_H + ii * MS + kk);
				r.b_addr    = AW'(OFF_PHT + kk * MM + jj);
				r.dest_addr = AW'(OFF_S + ii * MM + jj);
			end
			PH_UDET: begin
				r.ni = CW'(1); r.nj = CW'(1); r.dest_det = 1'b1;
				if (nm == CW'(1)) begin
					r.init      = INIT_MEM;
					r.init_addr = AW'(OFF_S);
				end else begin
					// s00*s11 - s01*s10
					r.nterms = CW'(2);
					r.tneg   = (kk == 1);
					r.a_addr = AW'(OFF_S + kk);
					r.b_addr = AW'(OFF_S + MM + 1 - kk);
				end
			end
			PH_UINV: begin
				r.ni = CW'(2); r.nj = CW'(2); r.is_div = 1'b1;
				r.init      = INIT_MEM;
				r.num_neg   = (ii != jj);
				r.init_addr = (ii == jj) ? AW'(OFF_S + (1 - ii) * (MM + 1))
				                         : AW'(OFF_S + ii * MM + jj);
				r.dest_addr = AW'(OFF_SI + ii * MM + jj);
			end
			PH_UK: begin
				r.ni = ns; r.nj = nm;
				r.dest_addr = AW'(OFF_KG + ii * MM + jj);
				if (nm == CW'(1)) begin
					r.is_div    = 1'b1;
					r.init      = INIT_MEM;
					r.init_addr = AW'(OFF_PHT + ii * MM);
				end else begin
					r.nterms = CW'(2);
					r.a_addr = AW'(OFF_PHT + ii * MM + kk);
					r.b_addr = AW'(OFF_SI + kk * MM + jj);
				end
			end
			PH_UX: begin
				r.ni = ns; r.nj = CW'(1); r.nterms = nm;
				r.init      = INIT_MEM;
				r.init_addr = AW'(OFF_X + ii);
				r.a_addr    = AW'(OFF_KG + ii * MM + kk);
				r.b_addr    = AW'(OFF_Y + kk);
				r.dest_addr = AW'(OFF_XN + ii);
			end
			PH_UM: begin
				r.ni = ns; r.nj = ns; r.nterms = nm;
				r.init      = INIT_ONE_DIAG;
				r.tneg      = 1'b1;
				r.a_addr    = AW'(OFF_KG + ii * MM + kk);
				r.b_addr    = AW'(OFF_H + kk * MS + jj);
				r.dest_addr = AW'(OFF_T + ii * MS + jj);
			end
			PH_UPN: begin
				r.ni = ns; r.nj = ns; r.nterms = ns;
				r.a_addr    = AW'(OFF_T + ii * MS + kk);
				r.b_addr    = AW'(OFF_P + kk * MS + jj);
				r.dest_addr = AW'(OFF_PN + ii * MS + jj);
			end
			PH_CX: begin
				r.ni = ns; r.nj = CW'(1);
				r.init      = INIT_MEM;
				r.init_addr = AW'(OFF_XN + ii);
				r.dest_addr = AW'(OFF_X + ii);
			end
			PH_CP: begin
				r.ni = ns; r.nj = ns;
				r.init      = INIT_MEM;
				r.init_addr = AW'(OFF_PN + ii * MS + jj);
				r.dest_addr = AW'(OFF_P + ii * MS + jj);
			end
			default: begin
				r.ni = CW'(1); r.nj = CW'(1);
			end
		endcase
		return r;
	endfunction

	function automatic phase_t next_phase_f(input phase_t ph, input logic [CW-1:0] nm);
		phase_t n;
		case (ph)
			PH_PX:   n = PH_PT;
			PH_PT:   n = PH_PP;
			PH_PP:   n = PH_CX;
			PH_UY:   n = PH_UPHT;
			PH_UPHT: n = PH_US;
			PH_US:   n = PH_UDET;
			PH_UDET: n = (nm == CW'(2)) ? PH_UINV : PH_UK;
			PH_UINV: n = PH_UK;
			PH_UK:   n = PH_UX;
			PH_UX:   n = PH_UM;
			PH_UM:   n = PH_UPN;
			PH_UPN:  n = PH_CX;
			PH_CX:   n = PH_CP;
			default: n = PH_CP;
		endcase
		return n;
	endfunction

	// control state
	state_t        state_q, state_d;
	phase_t        phase_q;
	logic [CW-1:0] i_q, j_q, k_q;
	logic [CW-1:0] ns_q, nm_q, nc_q;
	logic          sat_q;
	logic          rsp_valid_q;
	logic          vld_q [BANK_DEPTH];

	// datapath
	logic signed [63:0] acc_q, prod_q, det_q;
	logic signed [31:0] a_q, v0_q, v1_q, res_val_q;
	logic [1:0]         res_sts_q;
	rsp_item_t          rsp_data_q;
	logic [63:0]        div_rem_q, div_quo_q, div_den_q;
	logic [5:0]         div_cnt_q;
	logic               div_neg_q;
	logic               rd_zero_q;

	// RAM port
	logic          ram_we;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [31:0]   ram_wdata, ram_rdata;

	desc_t              dsc;
	logic               cmd_acc;
	logic               loc_ok;
	logic [AW-1:0]      loc_addr;
	logic signed [31:0] rd_eff;
	logic signed [31:0] u_val;
	logic signed [63:0] init_val;
	logic signed [63:0] term_q;
	logic signed [31:0] wb_val;
	logic               wb_ovf;
	logic               last_j, last_i, last_k;
	logic signed [63:0] num_s, num_sh, den_abs;
	logic [63:0]        rem_sh;
	logic               rsp_load;

	assign cmd_acc  = cmd.valid && cmd.ready;
	assign rsp_load = (state_q == ST_DONE) && (!rsp_valid_q || rsp.ready);
	assign dsc      = desc_f(phase_q, i_q, j_q, k_q, ns_q, nm_q, nc_q);
	assign rd_eff   = rd_zero_q ? 32'sd0 : $signed(ram_rdata);

	// element locate for write/read items
	always_comb begin
		int r;
		int c;
		int ns;
		int nm;
		int nc;
		r  = int'(cmd.data.row_index);
		c  = int'(cmd.data.col_index);
		ns = int'(ns_q);
		nm = int'(nm_q);
		nc = int'(nc_q);
		loc_ok   = 1'b0;
		loc_addr = '0;
		case (cmd.data.matrix_sel)
			SEL_F: begin loc_ok = r < ns && c < ns; loc_addr = AW'(OFF_F + r * MS + c); end
			SEL_B: begin loc_ok = r < ns && c < nc; loc_addr = AW'(OFF_B + r * MC + c); end
			SEL_Q: begin loc_ok = r < ns && c < ns; loc_addr = AW'(OFF_Q + r * MS + c); end
			SEL_H: begin loc_ok = r < nm && c < ns; loc_addr = AW'(OFF_H + r * MS + c); end
			SEL_R: begin loc_ok = r < nm && c < nm; loc_addr = AW'(OFF_R + r * MM + c); end
			SEL_X: begin loc_ok = r < ns && c == 0; loc_addr = AW'(OFF_X + r); end
			SEL_P: begin loc_ok = r < ns && c < ns; loc_addr = AW'(OFF_P + r * MS + c); end
			default: begin loc_ok = 1'b0; loc_addr = '0; end
		endcase
	end

	// arithmetic helpers
	always_comb begin
		case (dsc.u_idx)
			CW'(0):  u_val = v0_q;
			CW'(1):  u_val = v1_q;
			default: u_val = 32'sd0;
		endcase
		case (dsc.init)
			INIT_ZERO:     init_val = 64'sd0;
			INIT_ONE_DIAG: init_val = (i_q == j_q) ? ONE : 64'sd0;
			INIT_MEM:      init_val = 64'(rd_eff);
			INIT_ZIN:      init_val = (i_q == '0) ? 64'(v0_q) : 64'(v1_q);
			default:       init_val = 64'sd0;
		endcase
		term_q  = (prod_q + HALF) >>> FRAC_BITS;
		wb_ovf  = (acc_q > SMAX) || (acc_q < SMIN);
		wb_val  = wb_ovf ? (acc_q[63] ? 32'sh80000000 : 32'sh7FFFFFFF) : acc_q[31:0];
		last_k  = (k_q + CW'(1)) >= dsc.nterms;
		last_j  = (j_q + CW'(1)) >= dsc.nj;
		last_i  = (i_q + CW'(1)) >= dsc.ni;
		num_s   = dsc.num_neg ? -64'(rd_eff) : 64'(rd_eff);
		num_sh  = num_s <<< FRAC_BITS;
		den_abs = det_q[63] ? -det_q : det_q;
		rem_sh  = {div_rem_q[62:0], div_quo_q[63]};
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd_acc) begin
					case (cmd.data.operation)
						OP_READ:    state_d = loc_ok ? ST_RD : ST_DONE;
						OP_PREDICT: state_d = ST_ELEM;
						OP_UPDATE:  state_d = ST_ELEM;
						default:    state_d = ST_DONE;
					endcase
				end
			end
			ST_RD:   state_d = ST_DONE;
			ST_ELEM: state_d = ST_INIT;
			ST_INIT: begin
				if (dsc.is_div) begin
					state_d = ST_DIV;
				end else if (dsc.nterms == '0) begin
					state_d = ST_WB;
				end else begin
					state_d = ST_RA;
				end
			end
			ST_RA:   state_d = ST_RB;
			ST_RB:   state_d = ST_MUL;
			ST_MUL:  state_d = ST_ACC;
			ST_ACC:  state_d = last_k ? ST_WB : ST_RA;
			ST_DIV:  state_d = (div_cnt_q == 6'd63) ? ST_DIVF : ST_DIV;
			ST_DIVF: state_d = ST_WB;
			ST_WB: begin
				if (dsc.dest_det && acc_q == 64'sd0) begin
					state_d = ST_DONE;
				end else if (last_j && last_i && phase_q == PH_CP) begin
					state_d = ST_DONE;
				end else begin
					state_d = ST_ELEM;
				end
			end
			ST_DONE: state_d = rsp_load ? ST_IDLE : ST_DONE;
			default: state_d = ST_IDLE;
		endcase
	end

	// RAM and handshake controls
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = dsc.dest_addr;
		ram_wdata = wb_val;
		ram_raddr = dsc.init_addr;
		case (state_q)
			ST_IDLE: begin
				ram_we    = cmd_acc && cmd.data.operation == OP_WRITE && loc_ok;
				ram_waddr = loc_addr;
				ram_wdata = cmd.data.elem_value;
				ram_raddr = loc_addr;
			end
			ST_RA:   ram_raddr = dsc.a_addr;
			ST_RB:   ram_raddr = dsc.b_addr;
			ST_WB:   ram_we = !dsc.dest_det;
			default: ram_raddr = dsc.init_addr;
		endcase
	end

	assign cmd.ready = (state_q == ST_IDLE);
	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_data_q;

	kfpu_ram #(
		.WIDTH (32),
		.DEPTH (MEM_DEPTH)
	) u_bank (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			phase_q     <= PH_PX;
			i_q         <= '0;
			j_q         <= '0;
			k_q         <= '0;
			sat_q       <= 1'b0;
			rsp_valid_q <= 1'b0;
			ns_q        <= CW'(NS_RST);
			nm_q        <= CW'(1);
			nc_q        <= CW'(1);
			for (int n = 0; n < BANK_DEPTH; n++) begin
				vld_q[n] <= 1'b0;
			end
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				// the state size takes all 3 data bits, the measurement and control sizes the low 2
				case (cfg_index)
					CFG_STATE_SIZE: ns_q <= clamp_f(cfg_data, MS);
					CFG_MEAS_SIZE:  nm_q <= clamp_f(CFG_DATA_W'(cfg_data[1:0]), MM);
					CFG_CTRL_SIZE:  nc_q <= clamp_f(CFG_DATA_W'(cfg_data[1:0]), MC);
					default:        ns_q <= ns_q;
				endcase
			end
			if (ram_we && ram_waddr < AW'(BANK_DEPTH)) begin
				vld_q[ram_waddr[BW-1:0]] <= 1'b1;
			end
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					i_q   <= '0;
					j_q   <= '0;
					k_q   <= '0;
					sat_q <= 1'b0;
					phase_q <= (cmd.data.operation == OP_UPDATE) ? PH_UY : PH_PX;
				end
				ST_ACC: k_q <= k_q + CW'(1);
				ST_WB: begin
					k_q <= '0;
					if (!dsc.dest_det) begin
						sat_q <= sat_q | wb_ovf;
					end
					if (!last_j) begin
						j_q <= j_q + CW'(1);
					end else begin
						j_q <= '0;
						if (!last_i) begin
							i_q <= i_q + CW'(1);
						end else begin
							i_q     <= '0;
							phase_q <= next_phase_f(phase_q, nm_q);
						end
					end
				end
				default: k_q <= k_q;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		rd_zero_q <= (ram_raddr < AW'(BANK_DEPTH)) && !vld_q[ram_raddr[BW-1:0]];
		if (rsp_load) begin
			rsp_data_q.read_value <= res_val_q;
			rsp_data_q.status     <= res_sts_q;
		end
		case (state_q)
			ST_IDLE: begin
				v0_q      <= cmd.data.vector_first;
				v1_q      <= cmd.data.vector_second;
				res_val_q <= 32'sd0;
				res_sts_q <= loc_ok ? STS_OK : STS_RANGE;
			end
			ST_RD: res_val_q <= rd_eff;
			ST_INIT: begin
				acc_q     <= init_val;
				div_quo_q <= (num_sh[63] ? -num_sh : num_sh) + (den_abs >>> 1);
				div_rem_q <= '0;
				div_den_q <= den_abs;
				div_neg_q <= num_sh[63] ^ det_q[63];
				div_cnt_q <= '0;
			end
			ST_RB:  a_q    <= rd_eff;
			ST_MUL: prod_q <= 64'(a_q) * 64'(dsc.b_in ? u_val : rd_eff);
			ST_ACC: acc_q  <= dsc.tneg ? acc_q - term_q : acc_q + term_q;
			ST_DIV: begin
				div_cnt_q <= div_cnt_q + 6'd1;
				if (rem_sh >= div_den_q) begin
					div_rem_q <= rem_sh - div_den_q;
					div_quo_q <= {div_quo_q[62:0], 1'b1};
				end else begin
					div_rem_q <= rem_sh;
					div_quo_q <= {div_quo_q[62:0], 1'b0};
				end
			end
			ST_DIVF: acc_q <= div_neg_q ? -$signed(div_quo_q) : $signed(div_quo_q);
			ST_WB: begin
				if (dsc.dest_det) begin
					det_q <= acc_q;
					if (acc_q == 64'sd0) begin
						res_sts_q <= STS_SINGULAR;
					end
				end else if (last_j && last_i && phase_q == PH_CP) begin
					res_sts_q <= (sat_q | wb_ovf) ? STS_SAT : STS_OK;
				end
			end
			default: a_q <= a_q;
		endcase
	end

`ifndef SYNTH
	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> div_den_q != '0)
		else $error("divider running with zero divisor");

	a_idle_write: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we && state_q != ST_WB |->
			state_q == ST_IDLE && cmd.valid && cmd.data.operation == OP_WRITE)
		else $error("bank written outside an element write or write-back");

	a_term_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ACC |-> k_q < dsc.nterms)
		else $error("term counter past its bound");

	a_singular_ends: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_WB && dsc.dest_det && acc_q == 64'sd0 |=> state_q == ST_DONE)
		else $error("singular S did not end the update");
`endif

endmodule

`default_nettype wire

FILE: sv/kfpu_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none

module kfpu_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire
